// ===== design/fifo_queue_with_search_replace_macros.svh =====
// Assertion macros for the FIFO queue with search and replace.
// Used by the control module; no other dependencies.
`ifndef FIFO_QUEUE_WITH_SEARCH_REPLACE_MACROS_SVH
`define FIFO_QUEUE_WITH_SEARCH_REPLACE_MACROS_SVH
`ifndef SYNTHESIS
`define FQSR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fqsr assertion failed");
`define FQSR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fqsr assertion failed");
`else
`define FQSR_ASSERT(lbl, clk, rst_n, prop)
`define FQSR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== design/fqsr_pkg.sv =====
// Package for the FIFO queue with search and replace: codes, state and control types.
// No dependencies.
`timescale 1ns / 1ps
package fqsr_pkg;

  localparam logic [2:0] MODE_INSERT  = 3'd0;
  localparam logic [2:0] MODE_DELETE  = 3'd1;
  localparam logic [2:0] MODE_PEEK    = 3'd2;
  localparam logic [2:0] MODE_DISPLAY = 3'd3;
  localparam logic [2:0] MODE_CHANGE  = 3'd4;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISP,
    ST_CHG
  } state_t;

  typedef struct packed {
    logic        shift;
    logic        ins;
    logic [31:0] ins_data;
    logic [31:0] wrap_data;
  } ctl_t;

  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctrl_t;

endpackage

// ===== design/fqsr_if.sv =====
// Handshake channel interfaces for the FIFO queue: operation in, result out.
// No dependencies.
`timescale 1ns / 1ps
interface fqsr_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic signed [31:0] item_value;
  logic signed [31:0] new_value;
  modport source (output valid, mode, item_value, new_value, input ready);
  modport sink (input valid, mode, item_value, new_value, output ready);
endinterface

interface fqsr_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic signed [31:0] data_out;
  logic              last;
  modport source (output valid, status, data_out, last, input ready);
  modport sink (input valid, status, data_out, last, output ready);
endinterface

// ===== design/fifo_queue_with_search_replace.sv =====
// FIFO queue with search and replace: top level, chain of entry cells plus controller.
// Depends on fqsr_pkg, fqsr_if, fqsr_cell and fqsr_ctrl.
//
// Usage:
//   in_ch carries one operation per transfer (mode, item_value, new_value);
//   out_ch carries results (status, data_out, last), last set on the final
//   result of each operation. Unused modes produce no result.
//   Entries sit in a chain of DEPTH cells, oldest in cell 0. Insert writes the
//   cell at the fill count; delete shifts the chain one cell toward the head.
//   Insert, delete, peek and operations on an empty queue finish in the
//   accepting cycle and give their result in the next cycle.
//   Display and change rotate the whole chain once, one cell per cycle while the
//   result slot is free, after the accepting cycle; display yields one
//   result per live entry during the rotation, change compares at cell 0 and
//   feeds the new value into the last cell as the first matching entry wraps around.
//   A simple operation can be followed directly by the next; display and change
//   hold off new operations until the rotation of the cell chain completes.
//   Reset empties the queue at once; cell contents are not cleared.
//   A stalled receiver holds the result register; the rotation and new
//   transfers on in_ch wait until the result is taken.
`timescale 1ns / 1ps
module fifo_queue_with_search_replace #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  fqsr_in_if.sink    in_ch,
  fqsr_out_if.source out_ch
);
  import fqsr_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  ctl_t          ctl;
  logic [CW-1:0] cnt;
  logic [31:0]   cell_q [DEPTH];

  fqsr_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .head   (cell_q[0]),
    .ctl    (ctl),
    .cnt    (cnt)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t  cc;
    logic [31:0] nb;
    assign cc.shift = ctl.shift;
    assign cc.wr    = ctl.ins && (cnt == CW'(i));
    if (i == DEPTH - 1) begin : g_wrap
      assign nb = ctl.wrap_data;
    end else begin : g_link
      assign nb = cell_q[i+1];
    end
    fqsr_cell u_cell (
      .clk      (clk),
      .ctrl     (cc),
      .shift_in (nb),
      .wr_data  (ctl.ins_data),
      .data     (cell_q[i])
    );
  end

endmodule

// ===== design/fqsr_cell.sv =====
// One storage cell of the queue chain: holds an entry, shifts from its neighbor.
// Depends on fqsr_pkg.
`timescale 1ns / 1ps
module fqsr_cell (
  input  logic                clk,
  input  fqsr_pkg::cell_ctrl_t ctrl,
  input  logic [31:0]         shift_in,
  input  logic [31:0]         wr_data,
  output logic [31:0]         data
);
  import fqsr_pkg::*;

  logic [31:0] data_r;
  logic [31:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.wr) begin
      data_nxt = wr_data;
    end else if (ctrl.shift) begin
      data_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== design/fqsr_ctrl.sv =====
// Queue controller: operation decode, sequencer for display and change, result register.
// Depends on fqsr_pkg, fqsr_if and the assertion macros header.
`timescale 1ns / 1ps
`include "fifo_queue_with_search_replace_macros.svh"
module fqsr_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  fqsr_in_if.sink                       in_ch,
  fqsr_out_if.source                    out_ch,
  input  logic [31:0]                   head,
  output fqsr_pkg::ctl_t                ctl,
  output logic [$clog2(DEPTH+1)-1:0]    cnt
);
  import fqsr_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          found_r, found_nxt;
  logic [31:0]   item_r, new_r;

  logic          out_vr, out_v_nxt;
  logic [1:0]    out_status_r;
  logic [31:0]   out_data_r;
  logic          out_last_r;

  logic          slot_free, accept, pos_end, is_empty;
  logic          emit, e_last, replace, shift, ins;
  logic [1:0]    e_status;
  logic [31:0]   e_data;

  assign slot_free = !out_vr || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && slot_free;
  assign accept = in_ch.valid && in_ch.ready;
  assign pos_end = (pos_r == PW'(DEPTH - 1));
  assign is_empty = (cnt_r == '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !is_empty) begin
          if (in_ch.mode == MODE_DISPLAY) begin
            state_nxt = ST_DISP;
          end else if (in_ch.mode == MODE_CHANGE) begin
            state_nxt = ST_CHG;
          end
        end
      end
      ST_DISP, ST_CHG: begin
        if (slot_free && pos_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    emit     = 1'b0;
    e_status = STATUS_OK;
    e_data   = '0;
    e_last   = 1'b1;
    shift    = 1'b0;
    ins      = 1'b0;
    replace  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.mode)
            MODE_INSERT: begin
              emit = 1'b1;
              if (cnt_r == CW'(DEPTH)) begin
                e_status = STATUS_FULL;
              end else begin
                ins = 1'b1;
              end
            end
            MODE_DELETE, MODE_PEEK: begin
              emit = 1'b1;
              if (is_empty) begin
                e_status = STATUS_EMPTY;
              end else begin
                e_data = head;
                shift  = (in_ch.mode == MODE_DELETE);
              end
            end
            MODE_DISPLAY, MODE_CHANGE: begin
              if (is_empty) begin
                emit     = 1'b1;
                e_status = STATUS_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DISP: begin
        if (slot_free) begin
          shift  = 1'b1;
          emit   = (CW'(pos_r) < cnt_r);
          e_data = head;
          e_last = (CW'(pos_r) == cnt_r - CW'(1));
        end
      end
      ST_CHG: begin
        if (slot_free) begin
          shift   = 1'b1;
          replace = !found_r && (CW'(pos_r) < cnt_r) && (head == item_r);
          emit    = pos_end;
          e_status = (found_r || replace) ? STATUS_OK : STATUS_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    found_nxt = found_r;
    if (ins) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (shift && state_r == ST_IDLE) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    if (accept) begin
      pos_nxt   = '0;
      found_nxt = 1'b0;
    end else if (shift) begin
      pos_nxt = pos_r + PW'(1);
    end
    if (replace) begin
      found_nxt = 1'b1;
    end
    out_v_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_vr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pos_r   <= '0;
      found_r <= 1'b0;
      out_vr  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      found_r <= found_nxt;
      out_vr  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_ch.item_value;
      new_r  <= in_ch.new_value;
    end
    if (emit) begin
      out_status_r <= e_status;
      out_data_r   <= e_data;
      out_last_r   <= e_last;
    end
  end

  assign out_ch.valid    = out_vr;
  assign out_ch.status   = out_status_r;
  assign out_ch.data_out = out_data_r;
  assign out_ch.last     = out_last_r;

  assign ctl.shift     = shift;
  assign ctl.ins       = ins;
  assign ctl.ins_data  = in_ch.item_value;
  assign ctl.wrap_data = replace ? new_r : head;
  assign cnt           = cnt_r;

  `FQSR_ASSERT_ALWAYS(a_cnt_bound, clk, !rst_n || cnt_r <= CW'(DEPTH))
  `FQSR_ASSERT(a_cnt_hold_busy, clk, rst_n, (state_r != ST_IDLE) |=> (cnt_r == $past(cnt_r)))
  `FQSR_ASSERT(a_seq_done, clk, rst_n,
    (state_r != ST_IDLE && slot_free && pos_end) |=> (state_r == ST_IDLE))
  `FQSR_ASSERT(a_busy_nonempty, clk, rst_n, (state_r != ST_IDLE) |-> !is_empty)

endmodule
